// ===== rtl/ssre_pkg.sv =====
`timescale 1ns / 1ps
// ssre_pkg: shared codes, command and status types of the stack sort/reverse engine.
package ssre_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned OpW    = 3;
  localparam int unsigned SortW  = 5;
  localparam int unsigned StatW  = 2;

  // operation codes
  localparam logic [OpW-1:0] OP_PUSH    = 3'd0;
  localparam logic [OpW-1:0] OP_POP     = 3'd1;
  localparam logic [OpW-1:0] OP_SORT    = 3'd2;
  localparam logic [OpW-1:0] OP_REVERSE = 3'd3;
  localparam logic [OpW-1:0] OP_DRAIN   = 3'd4;

  // status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  // read address select
  typedef enum logic [2:0] {
    RD_TOP = 3'd0,  // entry_count - 1
    RD_I   = 3'd1,
    RD_J   = 3'd2,
    RD_JM1 = 3'd3,
    RD_JM2 = 3'd4
  } rd_sel_e;

  // write address/data select
  typedef enum logic [1:0] {
    WR_PUSH = 2'd0,  // store[count] = push value
    WR_JRD  = 2'd1,  // store[j] = read data
    WR_JKEY = 2'd2,  // store[j] = key
    WR_IRD  = 2'd3   // store[i] = read data
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef enum logic [2:0] {
    IDX_HOLD      = 3'd0,
    IDX_SORT_INIT = 3'd1,
    IDX_REV_INIT  = 3'd2,
    IDX_I_INC     = 3'd3,
    IDX_J_FROM_I  = 3'd4,
    IDX_J_DEC     = 3'd5,
    IDX_SWAP_STEP = 3'd6
  } idx_op_e;

  typedef struct packed {
    logic             capture;
    logic             rd_en;
    rd_sel_e          rd_sel;
    logic             wr_en;
    wr_sel_e          wr_sel;
    cnt_op_e          cnt_op;
    idx_op_e          idx_op;
    logic             key_ld;
    logic             resp;
    logic             resp_value;
    logic [StatW-1:0] resp_status;
    logic             resp_last;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           empty;
    logic           full;
    logic           sort_small;
    logic           i_at_count;
    logic           jm1_gt_lo;
    logic           key_less;
    logic           i_ge_j;
  } stat_t;

endpackage

// ===== rtl/ssre_dpath.sv =====
`timescale 1ns / 1ps
// ssre_dpath: stack store, index registers, comparator and result registers.
module ssre_dpath #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssre_pkg::cmd_t                      cmd_i,
  output ssre_pkg::stat_t                     stat_o,
  input  logic [ssre_pkg::OpW-1:0]            operation_i,
  input  logic signed [ssre_pkg::WordW-1:0]   push_value_i,
  input  logic [ssre_pkg::SortW-1:0]          sort_count_i,
  output logic signed [ssre_pkg::WordW-1:0]   out_value_o,
  output logic                                value_valid_o,
  output logic [ssre_pkg::StatW-1:0]          status_o,
  output logic                                last_o,
  output logic                                done_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned NW = (CW > ssre_pkg::SortW) ? CW : ssre_pkg::SortW;
  localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);

  logic signed [ssre_pkg::WordW-1:0] mem_q [STACK_DEPTH];
  logic signed [ssre_pkg::WordW-1:0] rdata_q;
  logic signed [ssre_pkg::WordW-1:0] key_q;
  logic signed [ssre_pkg::WordW-1:0] push_val_q;
  logic [ssre_pkg::OpW-1:0]          op_q;
  logic [ssre_pkg::SortW-1:0]        sort_cnt_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, lo_q, lo_d;

  logic [NW-1:0] sort_n_ext, count_ext, n_sat;
  logic [CW-1:0] lo_calc;
  logic [CW-1:0] rd_idx, wr_idx;
  logic signed [ssre_pkg::WordW-1:0] wr_data;

  logic signed [ssre_pkg::WordW-1:0] out_value_q;
  logic                              value_valid_q, last_q, done_q;
  logic [ssre_pkg::StatW-1:0]        status_q;

  // saturated sort length and lowest sorted slot
  assign sort_n_ext = NW'(sort_cnt_q);
  assign count_ext  = NW'(count_q);
  assign n_sat      = (sort_n_ext > count_ext) ? count_ext : sort_n_ext;
  assign lo_calc    = count_q - n_sat[CW-1:0];

  // captured command word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= operation_i;
      push_val_q <= push_value_i;
      sort_cnt_q <= sort_count_i;
    end
    if (cmd_i.key_ld) begin
      key_q <= rdata_q;
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      ssre_pkg::RD_TOP: rd_idx = count_q - CW'(1);
      ssre_pkg::RD_I:   rd_idx = i_q;
      ssre_pkg::RD_J:   rd_idx = j_q;
      ssre_pkg::RD_JM1: rd_idx = j_q - CW'(1);
      ssre_pkg::RD_JM2: rd_idx = j_q - CW'(2);
      default:          rd_idx = i_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      ssre_pkg::WR_PUSH: begin
        wr_idx  = count_q;
        wr_data = push_val_q;
      end
      ssre_pkg::WR_JRD: begin
        wr_idx  = j_q;
        wr_data = rdata_q;
      end
      ssre_pkg::WR_JKEY: begin
        wr_idx  = j_q;
        wr_data = key_q;
      end
      ssre_pkg::WR_IRD: begin
        wr_idx  = i_q;
        wr_data = rdata_q;
      end
      default: begin
        wr_idx  = j_q;
        wr_data = key_q;
      end
    endcase
  end

  // stack store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_idx[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_idx[AW-1:0]];
    end
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      ssre_pkg::CNT_INC: count_d = count_q + CW'(1);
      ssre_pkg::CNT_DEC: count_d = count_q - CW'(1);
      default:           count_d = count_q;
    endcase
  end

  always_comb begin
    i_d  = i_q;
    j_d  = j_q;
    lo_d = lo_q;
    unique case (cmd_i.idx_op)
      ssre_pkg::IDX_SORT_INIT: begin
        lo_d = lo_calc;
        i_d  = lo_calc + CW'(1);
      end
      ssre_pkg::IDX_REV_INIT: begin
        i_d = '0;
        j_d = count_q - CW'(1);
      end
      ssre_pkg::IDX_I_INC:    i_d = i_q + CW'(1);
      ssre_pkg::IDX_J_FROM_I: j_d = i_q;
      ssre_pkg::IDX_J_DEC:    j_d = j_q - CW'(1);
      ssre_pkg::IDX_SWAP_STEP: begin
        i_d = i_q + CW'(1);
        j_d = j_q - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q  <= i_d;
    j_q  <= j_d;
    lo_q <= lo_d;
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      out_value_q   <= cmd_i.resp_value ? rdata_q : '0;
      value_valid_q <= cmd_i.resp_value;
      status_q      <= cmd_i.resp_status;
      last_q        <= cmd_i.resp_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.resp;
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q >= DepthC);
  assign stat_o.sort_small = (n_sat < NW'(2));
  assign stat_o.i_at_count = (i_q == count_q);
  assign stat_o.jm1_gt_lo  = (j_q > (lo_q + CW'(1)));
  assign stat_o.key_less   = (key_q < rdata_q);
  assign stat_o.i_ge_j     = (i_q >= j_q);

  assign out_value_o   = out_value_q;
  assign value_valid_o = value_valid_q;
  assign status_o      = status_q;
  assign last_o        = last_q;
  assign done_o        = done_q;

endmodule

// ===== rtl/ssre_ctrl.sv =====
`timescale 1ns / 1ps
// ssre_ctrl: sequencer for push, pop, drain, insertion sort and reverse.
module ssre_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ssre_pkg::stat_t stat_i,
  output ssre_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISPATCH   = 4'd1;
  localparam logic [3:0] S_POP_RD     = 4'd2;
  localparam logic [3:0] S_POP_OUT    = 4'd3;
  localparam logic [3:0] S_SORT_RDKEY = 4'd4;
  localparam logic [3:0] S_SORT_KEY   = 4'd5;
  localparam logic [3:0] S_SORT_CMP   = 4'd6;
  localparam logic [3:0] S_SORT_PUT   = 4'd7;
  localparam logic [3:0] S_REV_RDA    = 4'd8;
  localparam logic [3:0] S_REV_RDB    = 4'd9;
  localparam logic [3:0] S_REV_SWAP1  = 4'd10;
  localparam logic [3:0] S_REV_SWAP2  = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_d = S_IDLE;
        cmd_o.resp_last = 1'b1;
        unique case (stat_i.op)
          ssre_pkg::OP_PUSH: begin
            cmd_o.resp = 1'b1;
            if (stat_i.full) begin
              cmd_o.resp_status = ssre_pkg::ST_FULL;
            end else begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = ssre_pkg::WR_PUSH;
              cmd_o.cnt_op = ssre_pkg::CNT_INC;
            end
          end
          ssre_pkg::OP_POP, ssre_pkg::OP_DRAIN: begin
            if (stat_i.empty) begin
              cmd_o.resp        = 1'b1;
              cmd_o.resp_status = ssre_pkg::ST_EMPTY;
            end else begin
              state_d = S_POP_RD;
            end
          end
          ssre_pkg::OP_SORT: begin
            if (stat_i.sort_small) begin
              cmd_o.resp = 1'b1;
            end else begin
              cmd_o.idx_op = ssre_pkg::IDX_SORT_INIT;
              state_d      = S_SORT_RDKEY;
            end
          end
          ssre_pkg::OP_REVERSE: begin
            if (stat_i.empty) begin
              cmd_o.resp        = 1'b1;
              cmd_o.resp_status = ssre_pkg::ST_EMPTY;
            end else begin
              cmd_o.idx_op = ssre_pkg::IDX_REV_INIT;
              state_d      = S_REV_RDA;
            end
          end
          default: cmd_o.resp = 1'b1;  // unused codes
        endcase
      end

      S_POP_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ssre_pkg::RD_TOP;
        cmd_o.cnt_op = ssre_pkg::CNT_DEC;
        state_d      = S_POP_OUT;
      end

      S_POP_OUT: begin
        cmd_o.resp       = 1'b1;
        cmd_o.resp_value = 1'b1;
        cmd_o.resp_last  = (stat_i.op == ssre_pkg::OP_POP) || stat_i.empty;
        state_d = ((stat_i.op == ssre_pkg::OP_DRAIN) && !stat_i.empty) ? S_POP_RD : S_IDLE;
      end

      S_SORT_RDKEY: begin
        if (stat_i.i_at_count) begin
          cmd_o.resp      = 1'b1;
          cmd_o.resp_last = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ssre_pkg::RD_I;
          cmd_o.idx_op = ssre_pkg::IDX_J_FROM_I;
          state_d      = S_SORT_KEY;
        end
      end

      S_SORT_KEY: begin
        cmd_o.key_ld = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ssre_pkg::RD_JM1;
        state_d      = S_SORT_CMP;
      end

      S_SORT_CMP: begin
        if (stat_i.key_less) begin
          // shift the larger entry up one slot
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ssre_pkg::WR_JRD;
          cmd_o.idx_op = ssre_pkg::IDX_J_DEC;
          if (stat_i.jm1_gt_lo) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = ssre_pkg::RD_JM2;
          end else begin
            state_d = S_SORT_PUT;
          end
        end else begin
          state_d = S_SORT_PUT;
        end
      end

      S_SORT_PUT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ssre_pkg::WR_JKEY;
        cmd_o.idx_op = ssre_pkg::IDX_I_INC;
        state_d      = S_SORT_RDKEY;
      end

      S_REV_RDA: begin
        if (stat_i.i_ge_j) begin
          cmd_o.resp      = 1'b1;
          cmd_o.resp_last = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ssre_pkg::RD_I;
          state_d      = S_REV_RDB;
        end
      end

      S_REV_RDB: begin
        cmd_o.key_ld = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ssre_pkg::RD_J;
        state_d      = S_REV_SWAP1;
      end

      S_REV_SWAP1: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ssre_pkg::WR_IRD;
        state_d      = S_REV_SWAP2;
      end

      S_REV_SWAP2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ssre_pkg::WR_JKEY;
        cmd_o.idx_op = ssre_pkg::IDX_SWAP_STEP;
        state_d      = S_REV_RDA;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/stack_sort_reverse_engine.sv =====
`timescale 1ns / 1ps
// stack_sort_reverse_engine: top level, bounded LIFO stack with sort, reverse and drain.
// Push, unused codes and error answers give one result word; pop gives the top word;
// drain gives every word, top first. Reverse swaps pairs from the ends inward; sort of n
// entries inserts each of the n-1 keys in turn, shifting larger entries up one slot.
// Cost is set by the stack store, which has one write port and one registered read port.
// Reset clears the entry count and the sequencer; store contents stay undefined.
// busy drops in the cycle the final word shows on done_o; results cannot be stalled.
module stack_sort_reverse_engine #(
  parameter int unsigned STACK_DEPTH = 16  // 2 .. 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [ssre_pkg::OpW-1:0]          operation_i,
  input  logic signed [ssre_pkg::WordW-1:0] push_value_i,
  input  logic [ssre_pkg::SortW-1:0]        sort_count_i,
  output logic signed [ssre_pkg::WordW-1:0] out_value_o,
  output logic                              value_valid_o,
  output logic [ssre_pkg::StatW-1:0]        status_o,
  output logic                              last_o,
  output logic                              done_o
);

  // command/status link between sequencer and datapath
  ssre_pkg::cmd_t  cmd;
  ssre_pkg::stat_t stat;

  // sequencer: decodes the captured operation and walks the store
  ssre_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // datapath: store, entry count, index registers, key compare, result word
  ssre_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .operation_i   (operation_i),
    .push_value_i  (push_value_i),
    .sort_count_i  (sort_count_i),
    .out_value_o   (out_value_o),
    .value_valid_o (value_valid_o),
    .status_o      (status_o),
    .last_o        (last_o),
    .done_o        (done_o)
  );

endmodule
